FILE: design/dcbr_pkg.sv
`default_nettype none

package dcbr_pkg;

    // Fixed widths of the per-channel running state and of the channel field.
    localparam int SUM_W = 40;
    localparam int CNT_W = 35;
    localparam int CH_W  = 2;

    // Step counter wide enough to count every bit of the sum pass.
    localparam int STEP_W = $clog2(SUM_W + 2);

    localparam logic [CNT_W-1:0] COUNT_START = 35'd10;
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

    localparam logic signed [SUM_W-1:0] SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_LIMIT  = 40'sd10000000000;
    localparam logic signed [SUM_W-1:0] SUM_NLIMIT = -40'sd10000000000;
    localparam logic [CNT_W-1:0]        CNT_LIMIT  = 35'd10000000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_WRITE,
        ST_EMIT,
        ST_HALVE,
        ST_PREP,
        ST_DIV,
        ST_FIX
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: design/dcbr_div.sv
`default_nettype none

module dcbr_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [dcbr_pkg::SUM_W-1:0] dividend,
    input  wire logic [dcbr_pkg::CNT_W-1:0] divisor,
    output logic      [dcbr_pkg::SUM_W-1:0] quotient,
    output dcbr_pkg::div_status_t          status
);
    import dcbr_pkg::*;

    // Restoring divider: one quotient bit per cycle, dividend bits shift out
    // of the top of the quotient register as quotient bits shift in below.
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CNT_W:0]   trial;
    logic [CNT_W+1:0] diff;
    logic             fits;

    assign trial = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};
    assign fits  = !diff[CNT_W+1];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[CNT_W:0] : trial;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    // The busy flag is the upper member of the status word.
    assign status   = {busy_reg, done_reg};

endmodule

`default_nettype wire

FILE: design/dc_bias_removal_unit.sv
// A sample transfer yields its corrected transfer after a bit-serial sum pass over the 41-bit
// result, a write-back and the load of the output register once any held result is taken.
// A new sample is taken only after the previous one has loaded the output register; a sample marked
// last then adds, per channel, the halving step and the 40-step bit-serial division of that channel.
// Reset (aresetn low at a clock edge) clears all sums and corrections to zero, sets
// every count to ten and empties the output register.
`default_nettype none

module dc_bias_removal_unit #(
    parameter int NUM_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input stream.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample, zero padded
    input  wire logic [dcbr_pkg::CH_W-1:0]             s_tuser,  // channel
    input  wire logic                                  s_tlast,  // last sample of block
    // Result stream.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((SAMPLE_BITS+8)/8)*8-1:0]      m_tdata   // corrected, zero padded
);
    import dcbr_pkg::*;

    localparam int OUT_W  = SAMPLE_BITS + 1;
    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MPAD_W = ((SAMPLE_BITS + 8) / 8) * 8 - OUT_W;

    localparam logic [SAMPLE_BITS-1:0] CORR_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] CORR_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SUM_W-1:0] CMAX_MAG =
        {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SUM_W-1:0] CMIN_MAG =
        {{(SUM_W-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Control sequencer.
    state_t state_reg, state_next;

    // Per-channel running state. Entries are read through the incoming channel index
    // or the sweep index and are all reset together, so these stay flip-flops.
    logic signed [SUM_W-1:0]       sum_arr_reg  [NUM_CHANNELS];
    logic        [CNT_W-1:0]       cnt_arr_reg  [NUM_CHANNELS];
    logic        [SAMPLE_BITS-1:0] corr_arr_reg [NUM_CHANNELS];

    // Bit-serial datapath. The sum, the sample, the count and the corrected
    // output each shift one bit per cycle, LSB first, through their own
    // registers; results shift in from the top so they end up aligned.
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W:0]    acc_reg;      // running sum, becomes sum plus sample
    logic [SUM_W:0]    smp_reg;      // sign-extended sample
    logic              acc_c_reg;
    logic [CNT_W-1:0]  cnt_sh_reg;   // count, becomes count plus one
    logic              cnt_c_reg;
    logic [OUT_W-1:0]  y_reg;        // corrected sample
    logic [OUT_W-1:0]  ncorr_reg;    // inverted correction
    logic              y_c_reg;

    // Captured item control.
    logic [IDX_W-1:0] idx_reg;
    logic             inr_reg;
    logic             last_reg;

    // End-of-block sweep.
    logic [IDX_W-1:0] eidx_reg;
    logic             neg_reg;

    // Output register.
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // Divider hookup.
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic [SUM_W-1:0] div_quotient;
    div_status_t      div_stat;

    logic emit_load;

    // Incoming sample fields.
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [IDX_W-1:0]       in_idx;
    logic                   in_range;

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_idx    = IDX_W'(s_tuser);
    assign in_range  = (32'(s_tuser) < NUM_CHANNELS);

    // Serial full-adder bits for the sum pass and the output subtraction.
    logic acc_bit, acc_carry, y_bit, y_carry;

    assign acc_bit   = acc_reg[0] ^ smp_reg[0] ^ acc_c_reg;
    assign acc_carry = (acc_reg[0] & smp_reg[0]) | (acc_c_reg & (acc_reg[0] ^ smp_reg[0]));
    assign y_bit     = smp_reg[0] ^ ncorr_reg[0] ^ y_c_reg;
    assign y_carry   = (smp_reg[0] & ncorr_reg[0]) | (y_c_reg & (smp_reg[0] ^ ncorr_reg[0]));

    // Sum write-back saturates when the 41-bit result leaves the 40-bit range.
    logic signed [SUM_W-1:0] sum_sat;

    always_comb begin
        if (acc_reg[SUM_W] != acc_reg[SUM_W-1]) begin
            sum_sat = acc_reg[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = acc_reg[SUM_W-1:0];
        end
    end

    // Halving of the swept channel: both sum and count are halved when either
    // magnitude exceeds the limit; the sum is rounded toward zero.
    logic signed [SUM_W-1:0] e_sum;
    logic        [CNT_W-1:0] e_cnt;
    logic signed [SUM_W-1:0] e_sum_adj;
    logic                    e_big;

    assign e_sum     = sum_arr_reg[eidx_reg];
    assign e_cnt     = cnt_arr_reg[eidx_reg];
    assign e_sum_adj = e_sum + $signed({{(SUM_W-1){1'b0}}, e_sum[SUM_W-1]});
    assign e_big     = (e_sum > SUM_LIMIT) || (e_sum < SUM_NLIMIT) || (e_cnt > CNT_LIMIT);

    assign div_dividend = e_sum[SUM_W-1] ? (~e_sum + SUM_W'(1)) : e_sum;

    // Quotient magnitude back to a signed correction, saturated to the sample range.
    logic [SAMPLE_BITS-1:0] corr_new;

    always_comb begin
        if (!neg_reg) begin
            corr_new = (div_quotient > CMAX_MAG) ? CORR_MAX
                                                 : div_quotient[SAMPLE_BITS-1:0];
        end else begin
            corr_new = (div_quotient > CMIN_MAG) ? CORR_MIN
                                                 : (~div_quotient[SAMPLE_BITS-1:0]
                                                    + SAMPLE_BITS'(1));
        end
    end

    dcbr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (e_cnt),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (step_reg == STEP_W'(SUM_W)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = last_reg ? ST_HALVE : ST_IDLE;
                end
            end
            ST_HALVE: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = (eidx_reg == IDX_W'(NUM_CHANNELS - 1)) ? ST_IDLE : ST_HALVE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_EMIT:  emit_load = !out_valid_reg || m_tready;
            ST_PREP:  div_start = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Serial datapath and item capture.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            step_reg   <= '0;
            idx_reg    <= in_idx;
            inr_reg    <= in_range;
            last_reg   <= s_tlast;
            acc_reg    <= in_range ? {sum_arr_reg[in_idx][SUM_W-1], sum_arr_reg[in_idx]}
                                   : '0;
            acc_c_reg  <= 1'b0;
            smp_reg    <= {{(SUM_W+1-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
            cnt_sh_reg <= in_range ? cnt_arr_reg[in_idx] : COUNT_START;
            cnt_c_reg  <= 1'b1;
            ncorr_reg  <= in_range ? ~{corr_arr_reg[in_idx][SAMPLE_BITS-1],
                                       corr_arr_reg[in_idx]}
                                   : '1;
            y_c_reg    <= 1'b1;
        end else if (state_reg == ST_ADD) begin
            step_reg  <= step_reg + STEP_W'(1);
            acc_reg   <= {acc_bit, acc_reg[SUM_W:1]};
            acc_c_reg <= acc_carry;
            smp_reg   <= {smp_reg[SUM_W], smp_reg[SUM_W:1]};
            if (step_reg < STEP_W'(CNT_W)) begin
                cnt_sh_reg <= {cnt_sh_reg[0] ^ cnt_c_reg, cnt_sh_reg[CNT_W-1:1]};
                cnt_c_reg  <= cnt_sh_reg[0] & cnt_c_reg;
            end
            if (step_reg < STEP_W'(OUT_W)) begin
                y_reg     <= {y_bit, y_reg[OUT_W-1:1]};
                ncorr_reg <= {1'b0, ncorr_reg[OUT_W-1:1]};
                y_c_reg   <= y_carry;
            end
        end
    end

    // Channel state: updated on write-back and during the end-of-block sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                sum_arr_reg[i]  <= '0;
                cnt_arr_reg[i]  <= COUNT_START;
                corr_arr_reg[i] <= '0;
            end
            eidx_reg <= '0;
            neg_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_WRITE && inr_reg) begin
                sum_arr_reg[idx_reg] <= sum_sat;
                // A carry out of the increment means the count was already full.
                cnt_arr_reg[idx_reg] <= cnt_c_reg ? COUNT_MAX : cnt_sh_reg;
            end
            if (state_reg == ST_EMIT) begin
                eidx_reg <= '0;
            end
            if (state_reg == ST_HALVE && e_big) begin
                sum_arr_reg[eidx_reg] <= {e_sum_adj[SUM_W-1], e_sum_adj[SUM_W-1:1]};
                cnt_arr_reg[eidx_reg] <= {1'b0, e_cnt[CNT_W-1:1]};
            end
            if (state_reg == ST_PREP) begin
                neg_reg <= e_sum[SUM_W-1];
            end
            if (state_reg == ST_FIX) begin
                corr_arr_reg[eidx_reg] <= corr_new;
                eidx_reg               <= eidx_reg + IDX_W'(1);
            end
        end
    end

    // Output register lets the next sample start while a result waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (emit_load) begin
            out_data_reg <= y_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{MPAD_W{1'b0}}, out_data_reg};

    // The divider must be idle whenever a new sample may be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("sample accepted while divider busy");

    // Write-back follows only a completed serial sum pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> ($past(state_reg) == ST_ADD))
        else $error("write-back without a sum pass");

    // A correction is stored only after the divider reported completion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) |-> $past(div_stat.done))
        else $error("correction written before quotient was ready");

    // Counts never fall below their start value, so the divisor is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |-> (e_cnt >= COUNT_START))
        else $error("channel count below start value");

endmodule

`default_nettype wire
